FILE: rtl/sync_framed_packet_receiver_crc16_defines.svh
// ----------------------------------------------------------------------------
// sync framed packet receiver assertion macros
// shared concurrent assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef SYNC_FRAMED_PACKET_RECEIVER_CRC16_DEFINES_SVH
`define SYNC_FRAMED_PACKET_RECEIVER_CRC16_DEFINES_SVH

// same-cycle implication, disabled in reset
`define SFPR_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("sfpr check failed");

// next-cycle implication, disabled in reset
`define SFPR_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("sfpr check failed");

`endif

FILE: rtl/sfpr_pkg.sv
// ----------------------------------------------------------------------------
// sfpr_pkg
// constants, types and functions of the sync framed packet receiver
// ----------------------------------------------------------------------------
package sfpr_pkg;

  localparam int MAX_FRAME_BYTES = 16;
  localparam int POS_W = 4;
  localparam int LEN_W = 5;

  localparam logic [7:0] SYNC_FIRST  = 8'hFF;
  localparam logic [7:0] SYNC_SECOND = 8'hCC;
  localparam logic [7:0] DEV_BASE    = 8'h0B;
  localparam logic [7:0] DEV_LINK1   = 8'h0C;
  localparam logic [7:0] DEV_LINK2   = 8'h0D;

  localparam logic [1:0] TAG_BASE  = 2'd0;
  localparam logic [1:0] TAG_LINK1 = 2'd1;
  localparam logic [1:0] TAG_LINK2 = 2'd2;

  localparam logic [1:0] REG_BASE_LEN  = 2'd0;
  localparam logic [1:0] REG_LINK1_LEN = 2'd1;
  localparam logic [1:0] REG_LINK2_LEN = 2'd2;

  localparam logic [LEN_W-1:0] MIN_LEN  = LEN_W'(5);
  localparam logic [LEN_W-1:0] MAX_LEN  = LEN_W'(MAX_FRAME_BYTES);
  localparam logic [LEN_W-1:0] NO_FRAME = '1;

  localparam logic [15:0] CRC_POLY = 16'h1021;

  typedef logic [LEN_W-1:0] len_t;

  // controller to datapath
  typedef struct packed {
    logic take;
    logic load;
  } sfpr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic frame_done;
    logic emit_last;
    logic out_open;
  } sfpr_stat_t;

  function automatic len_t clamp_len(len_t v);
    len_t r;
    if (v < MIN_LEN) begin
      r = MIN_LEN;
    end else if (v > MAX_LEN) begin
      r = MAX_LEN;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // crc-16/xmodem, one byte msb first
  function automatic logic [15:0] crc_feed(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

FILE: rtl/sfpr_ctrl.sv
// ----------------------------------------------------------------------------
// sfpr_ctrl
// controller: switches between receiving bytes and emitting a stored frame
// ----------------------------------------------------------------------------
module sfpr_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  sfpr_pkg::sfpr_stat_t stat,
  output sfpr_pkg::sfpr_cmd_t  cmd
);

  typedef enum logic [1:0] {
    ST_RECV = 2'b01,
    ST_EMIT = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  assign s_tready = (state == ST_RECV);
  assign cmd.take = s_tvalid && (state == ST_RECV);
  assign cmd.load = (state == ST_EMIT) && stat.out_open;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_RECV: begin
        if (cmd.take && stat.frame_done) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (cmd.load && stat.emit_last) state_next = ST_RECV;
      end
      default: state_next = ST_RECV;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RECV;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: rtl/sfpr_dp.sv
// ----------------------------------------------------------------------------
// sfpr_dp
// datapath: length registers, frame store, crc and the output register
// ----------------------------------------------------------------------------
module sfpr_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  sfpr_pkg::len_t       cfg_data,
  input  logic [7:0]           rx_byte,
  input  sfpr_pkg::sfpr_cmd_t  cmd,
  output sfpr_pkg::sfpr_stat_t stat,
  input  logic                 m_tready,
  output logic                 m_tvalid,
  output logic [7:0]           frame_byte,
  output logic [sfpr_pkg::POS_W-1:0] byte_position,
  output logic [1:0]           device_code,
  output logic                 crc_match,
  output logic                 last_byte
);

  sfpr_pkg::len_t base_len;
  sfpr_pkg::len_t link1_len;
  sfpr_pkg::len_t link2_len;

  logic [7:0] frame_store [sfpr_pkg::MAX_FRAME_BYTES];

  sfpr_pkg::len_t byte_index;
  sfpr_pkg::len_t byte_index_next;
  sfpr_pkg::len_t expected_length;
  sfpr_pkg::len_t expected_length_next;
  logic [1:0]     device_tag;
  logic [1:0]     device_tag_next;
  logic [15:0]    running_crc;
  logic [15:0]    running_crc_next;
  logic [7:0]     prev_byte;
  logic [7:0]     prev_byte_next;

  sfpr_pkg::len_t frame_len;
  sfpr_pkg::len_t frame_len_next;
  logic [1:0]     frame_dev;
  logic [1:0]     frame_dev_next;
  logic           crc_ok;
  logic           crc_ok_next;
  logic [sfpr_pkg::POS_W-1:0] emit_idx;

  logic                       store_we;
  logic [sfpr_pkg::POS_W-1:0] store_addr;
  logic                       dev_ok;
  logic [1:0]                 dev_sel;
  sfpr_pkg::len_t             len_sel;

  // length registers
  always_ff @(posedge clk) begin
    if (rst) begin
      base_len  <= sfpr_pkg::len_t'(9);
      link1_len <= sfpr_pkg::len_t'(5);
      link2_len <= sfpr_pkg::len_t'(10);
    end else if (cfg_we) begin
      unique case (cfg_index)
        sfpr_pkg::REG_BASE_LEN:  base_len  <= cfg_data;
        sfpr_pkg::REG_LINK1_LEN: link1_len <= cfg_data;
        sfpr_pkg::REG_LINK2_LEN: link2_len <= cfg_data;
        default: ;
      endcase
    end
  end

  // device byte decode
  always_comb begin
    dev_ok  = 1'b1;
    dev_sel = sfpr_pkg::TAG_BASE;
    len_sel = base_len;
    unique case (rx_byte)
      sfpr_pkg::DEV_BASE: begin
        dev_sel = sfpr_pkg::TAG_BASE;
        len_sel = base_len;
      end
      sfpr_pkg::DEV_LINK1: begin
        dev_sel = sfpr_pkg::TAG_LINK1;
        len_sel = link1_len;
      end
      sfpr_pkg::DEV_LINK2: begin
        dev_sel = sfpr_pkg::TAG_LINK2;
        len_sel = link2_len;
      end
      default: dev_ok = 1'b0;
    endcase
  end

  assign stat.frame_done = (byte_index >= sfpr_pkg::len_t'(3)) &&
                           (byte_index + sfpr_pkg::len_t'(1) == expected_length);
  assign stat.emit_last  = ({1'b0, emit_idx} + sfpr_pkg::len_t'(1) == frame_len);
  assign stat.out_open   = !m_tvalid || m_tready;

  // receive path
  always_comb begin
    byte_index_next      = byte_index;
    expected_length_next = expected_length;
    device_tag_next      = device_tag;
    running_crc_next     = running_crc;
    prev_byte_next       = prev_byte;
    frame_len_next       = frame_len;
    frame_dev_next       = frame_dev;
    crc_ok_next          = crc_ok;
    store_we             = 1'b0;
    store_addr           = byte_index[sfpr_pkg::POS_W-1:0];
    if (cmd.take) begin
      priority if (byte_index == sfpr_pkg::len_t'(0)) begin
        if (rx_byte == sfpr_pkg::SYNC_FIRST) begin
          store_we        = 1'b1;
          byte_index_next = sfpr_pkg::len_t'(1);
        end
      end else if (byte_index == sfpr_pkg::len_t'(1)) begin
        if (rx_byte == sfpr_pkg::SYNC_SECOND) begin
          store_we        = 1'b1;
          byte_index_next = sfpr_pkg::len_t'(2);
        end else if (rx_byte == sfpr_pkg::SYNC_FIRST) begin
          store_we        = 1'b1;
          store_addr      = '0;
          byte_index_next = sfpr_pkg::len_t'(1);
        end else begin
          byte_index_next      = '0;
          expected_length_next = sfpr_pkg::NO_FRAME;
          device_tag_next      = sfpr_pkg::TAG_BASE;
        end
      end else if (byte_index == sfpr_pkg::len_t'(2)) begin
        if (dev_ok) begin
          store_we             = 1'b1;
          expected_length_next = sfpr_pkg::clamp_len(len_sel);
          device_tag_next      = dev_sel;
          running_crc_next     = sfpr_pkg::crc_feed(16'h0000, rx_byte);
          byte_index_next      = sfpr_pkg::len_t'(3);
        end else begin
          byte_index_next      = '0;
          expected_length_next = sfpr_pkg::NO_FRAME;
          device_tag_next      = sfpr_pkg::TAG_BASE;
        end
      end else begin
        store_we        = 1'b1;
        prev_byte_next  = rx_byte;
        byte_index_next = byte_index + sfpr_pkg::len_t'(1);
        if (byte_index + sfpr_pkg::len_t'(2) < expected_length) begin
          running_crc_next = sfpr_pkg::crc_feed(running_crc, rx_byte);
        end
        if (stat.frame_done) begin
          crc_ok_next          = ({prev_byte, rx_byte} == running_crc);
          frame_len_next       = expected_length;
          frame_dev_next       = device_tag;
          byte_index_next      = '0;
          expected_length_next = sfpr_pkg::NO_FRAME;
          device_tag_next      = sfpr_pkg::TAG_BASE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (store_we) frame_store[store_addr] <= rx_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index      <= '0;
      expected_length <= sfpr_pkg::NO_FRAME;
      device_tag      <= sfpr_pkg::TAG_BASE;
      running_crc     <= '0;
      frame_len       <= sfpr_pkg::NO_FRAME;
      emit_idx        <= '0;
      m_tvalid        <= 1'b0;
    end else begin
      byte_index      <= byte_index_next;
      expected_length <= expected_length_next;
      device_tag      <= device_tag_next;
      running_crc     <= running_crc_next;
      frame_len       <= frame_len_next;
      if (cmd.load) begin
        emit_idx <= stat.emit_last ? '0 : emit_idx + 1'b1;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    prev_byte <= prev_byte_next;
    frame_dev <= frame_dev_next;
    crc_ok    <= crc_ok_next;
    if (cmd.load) begin
      frame_byte    <= frame_store[emit_idx];
      byte_position <= emit_idx;
      device_code   <= frame_dev;
      crc_match     <= crc_ok;
      last_byte     <= stat.emit_last;
    end
  end

endmodule

FILE: rtl/sync_framed_packet_receiver_crc16.sv
// ----------------------------------------------------------------------------
// sync_framed_packet_receiver_crc16
// hunts for sync bytes, stores a frame, checks its crc-16/xmodem and emits it
// ----------------------------------------------------------------------------
// channel   direction  fields
// s_*       in         tdata[7:0] rx_byte
// m_*       out        tdata[7:0] frame_byte, tdata[11:8] byte_position,
//                      tuser[1:0] device_code, tuser[2] crc_match, tlast last_byte
// cfg_*     in         cfg_index register, cfg_data[4:0] length value
//
// each device and payload byte updates the crc in the cycle it is taken
// a finished frame of n bytes is emitted one byte a cycle while m_tready is high,
// through the single read port of the frame store and one output register
// s_tready stays low while a frame is emitted
// m_tready low holds the output register and the emission count
// rst is synchronous and clears the hunt state and the output valid
// ----------------------------------------------------------------------------
module sync_framed_packet_receiver_crc16 (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // frame_byte, byte_position, zero fill
  output logic [2:0]  m_tuser,   // device_code, crc_match
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [4:0]  cfg_data
);

  sfpr_pkg::sfpr_cmd_t  cmd;
  sfpr_pkg::sfpr_stat_t stat;

  logic [7:0]                 frame_byte;
  logic [sfpr_pkg::POS_W-1:0] byte_position;
  logic [1:0]                 device_code;
  logic                       crc_match;

  sfpr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sfpr_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .rx_byte       (s_tdata),
    .cmd           (cmd),
    .stat          (stat),
    .m_tready      (m_tready),
    .m_tvalid      (m_tvalid),
    .frame_byte    (frame_byte),
    .byte_position (byte_position),
    .device_code   (device_code),
    .crc_match     (crc_match),
    .last_byte     (m_tlast)
  );

  assign m_tdata = {4'h0, byte_position, frame_byte};
  assign m_tuser = {crc_match, device_code};

endmodule

FILE: rtl/sfpr_checker.sv
// ----------------------------------------------------------------------------
// sfpr_checker
// port-level checks of the sync framed packet receiver, bound to the top
// ----------------------------------------------------------------------------
`include "sync_framed_packet_receiver_crc16_defines.svh"

module sfpr_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic [2:0]  m_tuser,
  input logic        m_tlast
);

  // stalled output holds
  `SFPR_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // stalled output keeps its side fields
  `SFPR_ASSERT_NEXT(a_side_hold, m_tvalid && !m_tready, $stable(m_tuser) && $stable(m_tlast))

  // no byte is taken in the middle of an emitted frame
  `SFPR_ASSERT_NOW(a_no_rx_in_frame, m_tvalid && !m_tlast, !s_tready)

  // frames are at least five bytes
  `SFPR_ASSERT_NOW(a_last_pos, m_tvalid && m_tlast, m_tdata[11:8] >= 4'd4)

  // emission runs without gaps and positions count up
  `SFPR_ASSERT_NEXT(a_pos_step, m_tvalid && m_tready && !m_tlast,
    m_tvalid && (m_tdata[11:8] == $past(m_tdata[11:8]) + 4'd1))

endmodule

bind sync_framed_packet_receiver_crc16 sfpr_checker u_sfpr_checker (.*);
